@@ hw/rtl/sgm_pkg.sv @@
// ----------------------------------------------------------------------------
// Sobel gradient magnitude package
// Shared types and constants for the Sobel gradient magnitude unit: payload
// words, controller states, and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package sgm_pkg;

   localparam int DEFAULT_MAX_LINE = 2048;

   localparam int PIXEL_WIDTH      = 8;
   localparam int LINE_WIDTH_WIDTH = 12;
   localparam int LINE_COUNT_WIDTH = 13;
   localparam int ROW_WIDTH        = 14;
   localparam int CSR_INDEX_WIDTH  = 1;
   localparam int CSR_DATA_WIDTH   = 13;

   localparam logic [LINE_WIDTH_WIDTH-1:0] LINE_WIDTH_RESET = 12'd512;
   localparam logic [LINE_COUNT_WIDTH-1:0] LINE_COUNT_RESET = 13'd512;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LINE_WIDTH = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LINE_COUNT = 1'b1;

   localparam logic [PIXEL_WIDTH-1:0] MAGNITUDE_MAX = 8'd255;

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] pixel;
      logic                   flush;
   } sgm_req_type;

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] magnitude;
      logic                   frame_last;
   } sgm_rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WINDOW,
      S_SQUARE,
      S_SUM,
      S_ROOT,
      S_OUTPUT
   } sgm_state_type;

   typedef struct packed {
      logic capture;
      logic window_step;
      logic square_step;
      logic sum_step;
      logic root_step;
      logic out_load;
   } sgm_cmd_type;

   typedef struct packed {
      logic result_valid;
      logic root_last;
      logic out_free;
   } sgm_status_type;

endpackage

@@ hw/rtl/sgm_controller.sv @@
// ----------------------------------------------------------------------------
// Sobel gradient magnitude controller
// State machine that steps one pixel word at a time through capture, window
// update, squaring, summing, the square root iterations and the result load.
// ----------------------------------------------------------------------------
module sgm_controller
   import sgm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  sgm_status_type status,
   output sgm_cmd_type    cmd
);

   sgm_state_type state_ff;
   sgm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_WINDOW;
            end
         end
         S_WINDOW: begin
            cmd.window_step = 1'b1;
            state_in        = status.result_valid ? S_SQUARE : S_IDLE;
         end
         S_SQUARE: begin
            cmd.square_step = 1'b1;
            state_in        = S_SUM;
         end
         S_SUM: begin
            cmd.sum_step = 1'b1;
            state_in     = S_ROOT;
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            if (status.root_last) begin
               state_in = S_OUTPUT;
            end
         end
         S_OUTPUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   // An accepted word always moves on to the window update.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_WINDOW))
      else $error("accepted word did not reach the window update");

   // The last root iteration hands over to the result load.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROOT && status.root_last) |=> (state_ff == S_OUTPUT))
      else $error("square root did not finish after its last step");

   // At most one command is issued in any cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command in one cycle");

endmodule

@@ hw/rtl/sgm_datapath.sv @@
// ----------------------------------------------------------------------------
// Sobel gradient magnitude datapath
// Line stores, 3x3 window, raster position counters, Sobel sums, squaring,
// an iterative eight-step square root and the result register.
// ----------------------------------------------------------------------------
module sgm_datapath
   import sgm_pkg::*;
#(
   parameter int MAX_LINE = DEFAULT_MAX_LINE
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  sgm_req_type                req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output sgm_rsp_type                rsp_payload,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  sgm_cmd_type                cmd,
   output sgm_status_type             status
);

   localparam int COL_W = $clog2(MAX_LINE);
   localparam int EW    = $clog2(MAX_LINE + 1);
   localparam int CW    = (EW > LINE_WIDTH_WIDTH) ? EW : LINE_WIDTH_WIDTH;

   // Configuration registers.
   logic [LINE_WIDTH_WIDTH-1:0] line_width_ff;
   logic [LINE_COUNT_WIDTH-1:0] line_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
         line_count_ff <= LINE_COUNT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LINE_WIDTH: line_width_ff <= csr_write_data[LINE_WIDTH_WIDTH-1:0];
            CSR_LINE_COUNT: line_count_ff <= csr_write_data[LINE_COUNT_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // Effective frame size.
   logic [CW-1:0]        width_eff;
   logic [ROW_WIDTH-1:0] count_eff;
   logic [ROW_WIDTH-1:0] count_p1;
   logic [ROW_WIDTH-1:0] count_p2;

   always_comb begin
      if (line_width_ff == '0) begin
         width_eff = CW'(1);
      end else if (CW'(line_width_ff) > CW'(MAX_LINE)) begin
         width_eff = CW'(MAX_LINE);
      end else begin
         width_eff = CW'(line_width_ff);
      end
      count_eff = (line_count_ff == '0) ? ROW_WIDTH'(1) : ROW_WIDTH'(line_count_ff);
      count_p1  = count_eff + ROW_WIDTH'(1);
      count_p2  = count_eff + ROW_WIDTH'(2);
   end

   // Position of the next word and the position of the word in flight.
   logic [COL_W-1:0]     col_ff;
   logic [COL_W-1:0]     col_in;
   logic [ROW_WIDTH-1:0] row_ff;
   logic [ROW_WIDTH-1:0] row_in;
   logic [COL_W-1:0]     col_cur_ff;
   logic [ROW_WIDTH-1:0] row_cur_ff;
   logic [PIXEL_WIDTH-1:0] px_ff;

   logic [COL_W-1:0]       col_adj;
   logic [ROW_WIDTH-1:0]   row_adj;
   logic [PIXEL_WIDTH-1:0] px_adj;

   always_comb begin
      logic [COL_W-1:0]     col_w;
      logic [ROW_WIDTH-1:0] row_w;
      if (CW'(col_ff) >= width_eff) begin
         col_w = '0;
         row_w = row_ff + ROW_WIDTH'(1);
      end else begin
         col_w = col_ff;
         row_w = row_ff;
      end
      col_adj = (row_w > count_eff) ? '0 : col_w;
      row_adj = row_w;
      px_adj  = (req_payload.flush || row_w >= count_eff) ? '0 : req_payload.pixel;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         col_cur_ff <= col_adj;
         row_cur_ff <= row_adj;
         px_ff      <= px_adj;
      end
   end

   // Line stores.
   logic [PIXEL_WIDTH-1:0] upper_mem [MAX_LINE];
   logic [PIXEL_WIDTH-1:0] middle_mem [MAX_LINE];
   logic [PIXEL_WIDTH-1:0] upper_rd_ff;
   logic [PIXEL_WIDTH-1:0] middle_rd_ff;
   logic [PIXEL_WIDTH-1:0] up_px;
   logic [PIXEL_WIDTH-1:0] mid_px;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         upper_rd_ff <= upper_mem[col_adj];
      end
      if (cmd.window_step) begin
         upper_mem[col_cur_ff] <= mid_px;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         middle_rd_ff <= middle_mem[col_adj];
      end
      if (cmd.window_step) begin
         middle_mem[col_cur_ff] <= px_ff;
      end
   end

   assign up_px  = (row_cur_ff >= ROW_WIDTH'(2)) ? upper_rd_ff : '0;
   assign mid_px = (row_cur_ff >= ROW_WIDTH'(1)) ? middle_rd_ff : '0;

   // Window update and Sobel sums.
   logic [PIXEL_WIDTH-1:0] win_ff [3][3];
   logic [PIXEL_WIDTH-1:0] win_in [3][3];
   logic [PIXEL_WIDTH-1:0] eval_win [3][3];
   logic                   col_zero;
   logic                   ended;
   logic                   result_valid;
   logic                   last_flag;
   logic signed [10:0]     gx;
   logic signed [10:0]     gy;
   logic signed [10:0]     gx_ff;
   logic signed [10:0]     gy_ff;
   logic                   last_ff;

   always_comb begin
      logic [PIXEL_WIDTH-1:0] new_col [3];
      logic [10:0]            gx_pos;
      logic [10:0]            gx_neg;
      logic [10:0]            gy_pos;
      logic [10:0]            gy_neg;
      logic [CW-1:0]          col_nx;

      col_zero = (col_cur_ff == '0);
      ended    = (row_cur_ff >= count_p1);

      new_col[0] = col_zero ? '0 : up_px;
      new_col[1] = col_zero ? '0 : mid_px;
      new_col[2] = col_zero ? '0 : px_ff;

      for (int r = 0; r < 3; r++) begin
         eval_win[r][0] = win_ff[r][1];
         eval_win[r][1] = win_ff[r][2];
         eval_win[r][2] = new_col[r];
      end

      gx_pos = 11'(eval_win[0][0]) + {2'b00, eval_win[1][0], 1'b0} + 11'(eval_win[2][0]);
      gx_neg = 11'(eval_win[0][2]) + {2'b00, eval_win[1][2], 1'b0} + 11'(eval_win[2][2]);
      gy_pos = 11'(eval_win[2][0]) + {2'b00, eval_win[2][1], 1'b0} + 11'(eval_win[2][2]);
      gy_neg = 11'(eval_win[0][0]) + {2'b00, eval_win[0][1], 1'b0} + 11'(eval_win[0][2]);
      gx     = signed'(gx_pos - gx_neg);
      gy     = signed'(gy_pos - gy_neg);

      if (col_zero) begin
         result_valid = (row_cur_ff >= ROW_WIDTH'(2)) && (row_cur_ff < count_p2);
      end else begin
         result_valid = (row_cur_ff >= ROW_WIDTH'(1)) && (row_cur_ff < count_p1);
      end
      last_flag = col_zero && (row_cur_ff == count_p1);

      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (ended) begin
               win_in[r][c] = '0;
            end else if (col_zero) begin
               win_in[r][c] = '0;
            end else begin
               win_in[r][c] = eval_win[r][c];
            end
         end
      end
      if (!ended && col_zero) begin
         win_in[0][2] = up_px;
         win_in[1][2] = mid_px;
         win_in[2][2] = px_ff;
      end

      col_nx = CW'(col_cur_ff) + CW'(1);
      if (ended) begin
         col_in = '0;
         row_in = '0;
      end else if (col_nx >= width_eff) begin
         col_in = '0;
         row_in = row_cur_ff + ROW_WIDTH'(1);
      end else begin
         col_in = col_nx[COL_W-1:0];
         row_in = row_cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (cmd.window_step) begin
         col_ff <= col_in;
         row_ff <= row_in;
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.window_step) begin
         gx_ff   <= gx;
         gy_ff   <= gy;
         last_ff <= last_flag;
      end
   end

   // Squares, sum and iterative square root.
   logic [19:0] sq_x_ff;
   logic [19:0] sq_y_ff;
   logic [9:0]  abs_x;
   logic [9:0]  abs_y;
   logic [20:0] sq_sum;
   logic [15:0] radicand_ff;
   logic        sat_ff;
   logic [7:0]  root_ff;
   logic [7:0]  root_bit_ff;
   logic [7:0]  root_try;
   logic [15:0] root_try_sq;

   assign abs_x       = gx_ff[10] ? 10'(-gx_ff) : gx_ff[9:0];
   assign abs_y       = gy_ff[10] ? 10'(-gy_ff) : gy_ff[9:0];
   assign sq_sum      = 21'(sq_x_ff) + 21'(sq_y_ff);
   assign root_try    = root_ff | root_bit_ff;
   assign root_try_sq = 16'(root_try) * 16'(root_try);

   always_ff @(posedge clock) begin
      if (cmd.square_step) begin
         sq_x_ff <= 20'(abs_x) * 20'(abs_x);
         sq_y_ff <= 20'(abs_y) * 20'(abs_y);
      end
      if (cmd.sum_step) begin
         radicand_ff <= sq_sum[15:0];
         sat_ff      <= (sq_sum[20:16] != '0);
         root_ff     <= '0;
         root_bit_ff <= 8'h80;
      end else if (cmd.root_step) begin
         if (root_try_sq <= radicand_ff) begin
            root_ff <= root_try;
         end
         root_bit_ff <= root_bit_ff >> 1;
      end
   end

   // Result register.
   logic        rsp_valid_ff;
   sgm_rsp_type rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_payload_ff.magnitude  <= sat_ff ? MAGNITUDE_MAX : root_ff;
         rsp_payload_ff.frame_last <= last_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign status.result_valid = result_valid;
   assign status.root_last    = root_bit_ff[0];
   assign status.out_free     = !rsp_valid_ff || !rsp_stall;

   // A new result is loaded only when the previous one is gone or leaving.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while a word was held");

   // The square root always works on a single trial bit.
   assert property (@(posedge clock) disable iff (reset)
      cmd.root_step |-> $onehot(root_bit_ff))
      else $error("square root trial bit is not one-hot");

   // The end of a frame returns the position counters to the origin.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.window_step && ended) |=> (col_ff == '0 && row_ff == '0))
      else $error("position counters not cleared at frame end");

endmodule

@@ hw/rtl/sobel_gradient_magnitude_unit.sv @@
// ----------------------------------------------------------------------------
// Sobel gradient magnitude unit
// 3x3 Sobel edge magnitude on a raster stream of 8-bit grey pixels, with
// zero padding outside the frame and a flag on the last result of a frame.
//
//   port group   direction   handshake             payload
//   req_         in          req_valid/req_stall   sgm_req_type (pixel, flush)
//   rsp_         out         rsp_valid/rsp_stall   sgm_rsp_type (magnitude, frame_last)
//   csr_         in          csr_write_enable      csr_index, csr_write_data
//
// A word with a result passes the window update, squaring, sum, the eight-step
// square root and result load; a word with none goes idle after the window update.
// Reset is synchronous; the line stores are not cleared and need no sweep.
// The result register holds one word while the next input word is taken.
// While a stalled result waits in the result register, the next finished
// result waits in the datapath and the input is stalled.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude_unit
   import sgm_pkg::*;
#(
   parameter int MAX_LINE = DEFAULT_MAX_LINE
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  sgm_req_type                req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output sgm_rsp_type                rsp_payload,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   sgm_cmd_type    cmd;
   sgm_status_type status;

   sgm_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sgm_datapath #(
      .MAX_LINE (MAX_LINE)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
